// ===== sv/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, constants and tables for the spaced-seed mask generator.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int MASK_WIDTH    = 64;
    localparam int MAX_POSITIONS = 10;
    localparam int COL_W         = $clog2(MASK_WIDTH);
    localparam int IDX_W         = 4;   // positions_n / chosen_k / index field width
    localparam int FIELD_COL_W   = 6;   // column_a / column_b field width
    localparam int LIMIT_W       = 7;   // column_limit register width
    localparam int COUNT_W       = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = LIMIT_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POSITIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHOSEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

    localparam logic [IDX_W-1:0]   RST_POSITIONS = 4'd1;
    localparam logic [IDX_W-1:0]   RST_CHOSEN    = 4'd1;
    localparam logic [LIMIT_W-1:0] RST_LIMIT     = 7'd64;

    typedef enum logic [1:0] {
        CMD_RESTART   = 2'd0,
        CMD_NEXT      = 2'd1,
        CMD_SWAP      = 2'd2,
        CMD_THRESHOLD = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_ARG   = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                   command;
        logic [FIELD_COL_W-1:0] column_a;
        logic [FIELD_COL_W-1:0] column_b;
        logic [IDX_W-1:0]       threshold_index;
    } t_in_word;

    typedef struct packed {
        logic [MASK_WIDTH-1:0] mask;
        logic [COUNT_W-1:0]    count_value;
        logic                  last_mask;
        logic [1:0]            status;
    } t_out_word;

    // one classified command on its way from front to back
    typedef struct packed {
        logic                  do_mask;
        logic                  do_swap;
        logic [MASK_WIDTH-1:0] base;
        logic [COUNT_W-1:0]    count;
        logic                  last;
        t_status               status;
        logic [COL_W-1:0]      col_a;
        logic [COL_W-1:0]      col_b;
    } t_job;

    typedef logic [MAX_POSITIONS:0][MAX_POSITIONS:0][COUNT_W-1:0] t_binom_tab;

    // Pascal triangle, built at elaboration
    function automatic t_binom_tab f_build_binom();
        t_binom_tab tab;
        tab = '0;
        for (int r = 0; r <= MAX_POSITIONS; r++) begin
            tab[r][0] = COUNT_W'(1);
            for (int c = 1; c <= r; c++) begin
                tab[r][c] = tab[r-1][c-1] + ((c <= r - 1) ? tab[r-1][c] : '0);
            end
        end
        return tab;
    endfunction

    localparam t_binom_tab BINOM = f_build_binom();

    typedef logic [MAX_POSITIONS:1][MASK_WIDTH-1:0][IDX_W-1:0] t_phase_tab;

    // pattern position of each mask bit for every period m, built at elaboration
    function automatic t_phase_tab f_build_phase();
        t_phase_tab tab;
        int         ph;
        tab = '0;
        for (int m = 1; m <= MAX_POSITIONS; m++) begin
            ph = 0;
            for (int b = 0; b < MASK_WIDTH; b++) begin
                tab[m][b] = IDX_W'(ph);
                ph = (ph == m - 1) ? 0 : ph + 1;
            end
        end
        return tab;
    endfunction

    localparam t_phase_tab PHASE = f_build_phase();

endpackage

// ===== sv/ssm_front.sv =====
// ----------------------------------------------------------------------------
// ssm_front
// Command intake: holds configuration and the combination state, classifies
// each word and builds the unpermuted base mask.
// ----------------------------------------------------------------------------
module ssm_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  ssm_pkg::t_in_word              i_word,
    output logic                           o_push,
    output ssm_pkg::t_job                  o_job
);

    localparam int MP = ssm_pkg::MAX_POSITIONS;
    localparam int IW = ssm_pkg::IDX_W;

    logic [IW-1:0]               r_n, n_n;
    logic [IW-1:0]               r_k, n_k;
    logic [ssm_pkg::LIMIT_W-1:0] r_limit, n_limit;
    logic [IW-1:0]               r_idx [MP];
    logic [IW-1:0]               n_idx [MP];
    logic                        r_active, n_active;

    logic                        shape_ok;
    logic [MP-1:0]               can_step;
    logic [IW-1:0]               sel;
    logic                        is_final;
    logic [IW-1:0]               step_val;
    logic [IW-1:0]               adv_idx [MP];
    logic [MP-1:0]               pat;
    logic [ssm_pkg::MASK_WIDTH-1:0] base;
    logic                        swap_bad;
    logic [ssm_pkg::LIMIT_W-1:0] col_a_w, col_b_w;

    assign shape_ok = (r_n >= IW'(1)) && (r_n <= IW'(MP)) &&
                      (r_k >= IW'(1)) && (r_k <= r_n);

    // rightmost position that can still move up
    always_comb begin
        can_step = '0;
        sel      = '0;
        for (int p = 0; p < MP; p++) begin
            can_step[p] = (IW'(p) < r_k) &&
                          ({1'b0, r_idx[p]} < ({1'b0, r_n} - {1'b0, r_k} + (IW+1)'(p)));
            if (can_step[p]) sel = IW'(p);
        end
        is_final = ~|can_step;
        step_val = r_idx[sel[IW-1:0]] + IW'(1);
        for (int q = 0; q < MP; q++) begin
            adv_idx[q] = r_idx[q];
            if (IW'(q) == sel) adv_idx[q] = step_val;
            else if (IW'(q) > sel && IW'(q) < r_k) adv_idx[q] = step_val + (IW'(q) - sel);
        end
    end

    // pattern and its period-n repetition
    always_comb begin
        pat = '0;
        for (int i = 0; i < MP; i++) begin
            for (int v = 0; v < MP; v++) begin
                if (IW'(i) < r_k && r_idx[i] == IW'(v)) pat[v] = 1'b1;
            end
        end
        base = '0;
        for (int b = 0; b < ssm_pkg::MASK_WIDTH; b++) begin
            for (int m = 1; m <= MP; m++) begin
                if (r_n == IW'(m)) base[b] = pat[ssm_pkg::PHASE[m][b]];
            end
        end
    end

    assign col_a_w  = ssm_pkg::LIMIT_W'(i_word.column_a);
    assign col_b_w  = ssm_pkg::LIMIT_W'(i_word.column_b);
    assign swap_bad = (i_word.column_a == i_word.column_b) ||
                      (col_a_w >= r_limit) || (col_b_w >= r_limit) ||
                      (col_a_w >= ssm_pkg::LIMIT_W'(ssm_pkg::MASK_WIDTH)) ||
                      (col_b_w >= ssm_pkg::LIMIT_W'(ssm_pkg::MASK_WIDTH));

    always_comb begin
        n_n      = r_n;
        n_k      = r_k;
        n_limit  = r_limit;
        n_idx    = r_idx;
        n_active = r_active;
        o_push   = i_accept;
        o_job         = '0;
        o_job.status  = ssm_pkg::ST_OK;
        o_job.col_a   = i_word.column_a[ssm_pkg::COL_W-1:0];
        o_job.col_b   = i_word.column_b[ssm_pkg::COL_W-1:0];

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                ssm_pkg::CFG_POSITIONS: begin
                    n_n      = i_cfg_data[IW-1:0];
                    n_active = 1'b0;
                end
                ssm_pkg::CFG_CHOSEN: begin
                    n_k      = i_cfg_data[IW-1:0];
                    n_active = 1'b0;
                end
                ssm_pkg::CFG_LIMIT: begin
                    n_limit = i_cfg_data;
                end
                default: ;
            endcase
        end

        if (i_accept) begin
            unique case (i_word.command)
                ssm_pkg::CMD_RESTART: begin
                    if (shape_ok) begin
                        for (int i = 0; i < MP; i++) begin
                            n_idx[i] = (IW'(i) < r_k) ? IW'(i) : '0;
                        end
                        n_active    = 1'b1;
                        o_job.count = ssm_pkg::BINOM[r_n][r_k];
                    end else begin
                        n_active     = 1'b0;
                        o_job.status = ssm_pkg::ST_BAD_ARG;
                    end
                end
                ssm_pkg::CMD_NEXT: begin
                    if (r_active) begin
                        o_job.do_mask = 1'b1;
                        o_job.base    = base;
                        o_job.last    = is_final;
                        if (is_final) n_active = 1'b0;
                        else          n_idx    = adv_idx;
                    end else begin
                        o_job.status = ssm_pkg::ST_EXHAUSTED;
                    end
                end
                ssm_pkg::CMD_SWAP: begin
                    if (swap_bad) o_job.status  = ssm_pkg::ST_BAD_ARG;
                    else          o_job.do_swap = 1'b1;
                end
                ssm_pkg::CMD_THRESHOLD: begin
                    if (shape_ok && i_word.threshold_index <= (r_n - r_k)) begin
                        o_job.count = ssm_pkg::BINOM[r_n - i_word.threshold_index][r_k];
                    end else begin
                        o_job.status = ssm_pkg::ST_BAD_ARG;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n      <= ssm_pkg::RST_POSITIONS;
            r_k      <= ssm_pkg::RST_CHOSEN;
            r_limit  <= ssm_pkg::RST_LIMIT;
            r_active <= 1'b0;
            for (int i = 0; i < MP; i++) r_idx[i] <= '0;
        end else begin
            r_n      <= n_n;
            r_k      <= n_k;
            r_limit  <= n_limit;
            r_active <= n_active;
            r_idx    <= n_idx;
        end
    end

    // final combination always drops the generator
    a_final_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_word.command == ssm_pkg::CMD_NEXT && r_active && is_final)
        |=> !r_active)
        else $error("generator still active after final combination");

    // a failed restart never leaves the generator running
    a_bad_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_word.command == ssm_pkg::CMD_RESTART && !shape_ok) |=> !r_active)
        else $error("generator active after bad restart");

endmodule

// ===== sv/ssm_queue.sv =====
// ----------------------------------------------------------------------------
// ssm_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module ssm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssm_pkg::t_job i_push_job,
    output logic          o_full,
    output logic          o_valid,
    output ssm_pkg::t_job o_job,
    input  logic          i_pop
);

    ssm_pkg::t_job r_slot [2];
    logic          r_wptr, r_rptr;
    logic [1:0]    r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop)      n_cnt = r_cnt + 2'd1;
        else if (do_pop && !do_push) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) r_wptr <= ~r_wptr;
            if (do_pop)  r_rptr <= ~r_rptr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wptr] <= i_push_job;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count out of range");

endmodule

// ===== sv/ssm_back.sv =====
// ----------------------------------------------------------------------------
// ssm_back
// Executes queued jobs: column swaps, permutation of base masks, and the
// output register toward the receiver.
// ----------------------------------------------------------------------------
module ssm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  ssm_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ssm_pkg::t_out_word o_out_word
);

    localparam int MW = ssm_pkg::MASK_WIDTH;
    localparam int CW = ssm_pkg::COL_W;

    logic [CW-1:0]      r_perm [MW];
    logic [CW-1:0]      n_perm [MW];
    logic               r_out_valid;
    ssm_pkg::t_out_word r_out_word, n_out_word;
    logic [MW-1:0]      permuted;

    assign o_pop = i_job_valid && (!r_out_valid || i_out_ready);

    // output bit p takes base bit perm[p]
    always_comb begin
        for (int p = 0; p < MW; p++) permuted[p] = i_job.base[r_perm[p]];
    end

    always_comb begin
        n_perm = r_perm;
        if (o_pop && i_job.do_swap) begin
            n_perm[i_job.col_a] = r_perm[i_job.col_b];
            n_perm[i_job.col_b] = r_perm[i_job.col_a];
        end
        n_out_word.mask        = i_job.do_mask ? permuted : '0;
        n_out_word.count_value = i_job.count;
        n_out_word.last_mask   = i_job.last;
        n_out_word.status      = i_job.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int p = 0; p < MW; p++) r_perm[p] <= CW'(p);
        end else begin
            r_perm <= n_perm;
            if (o_pop)            r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_swap_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_job.do_swap) |=>
        (r_perm[$past(i_job.col_a)] == $past(r_perm[i_job.col_b])))
        else $error("swap did not move column entry");

    a_mask_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.mask != '0) |->
        (r_out_word.status == ssm_pkg::ST_OK))
        else $error("nonzero mask with error status");

endmodule

// ===== sv/spaced_seed_mask_generator_top.sv =====
// ----------------------------------------------------------------------------
// spaced_seed_mask_generator_top
// Enumerates k-of-n seed patterns, tiles them into permuted 64-bit masks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one command word
//   per cycle while o_in_ready is high: restart, next mask, swap columns, or
//   threshold read. Output channel (o_out_valid / i_out_ready / o_out_word)
//   returns exactly one result word per command, in order.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data) writes positions_n,
//   chosen_k and column_limit; write only while the block is idle.
//   Path: an accepted word is first written into the queue, then into the
//   output register once that register is free or being read.
//   Throughput: one word per cycle while the receiver is ready; the next-mask
//   path (advance of the index set plus the 64 column muxes) is the per-cycle limit.
//   Reset: n = k = 1, column_limit = 64, generator not started, identity
//   column permutation, queue and output empty.
//   Receiver stall: the output register holds; the two-entry queue keeps
//   filling, and o_in_ready drops once it is full.
// ----------------------------------------------------------------------------
module spaced_seed_mask_generator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ssm_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ssm_pkg::t_out_word             o_out_word
);

    logic          q_full;
    logic          accept;
    logic          push;
    ssm_pkg::t_job push_job;
    logic          job_valid;
    ssm_pkg::t_job job;
    logic          pop;

    // front only needs queue room
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && !q_full;

    ssm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_word      (i_in_word),
        .o_push      (push),
        .o_job       (push_job)
    );

    ssm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (q_full),
        .o_valid    (job_valid),
        .o_job      (job),
        .i_pop      (pop)
    );

    // swaps execute here, in order with the masks that follow them
    ssm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
